// File: rtl/core/lptt_pkg.sv
// Shared operation and status codes for the linear probe type table.
// No dependencies; imported by the table core.
`timescale 1ns / 1ps

package lptt_pkg;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_INSERT   = 3'd0;
    localparam op_t OP_FIND_ID  = 3'd1;
    localparam op_t OP_HAS_TRT  = 3'd2;
    localparam op_t OP_SUBTYPE  = 3'd3;
    localparam op_t OP_FIND_CRC = 3'd4;
    localparam op_t OP_READ_IDX = 3'd5;
    localparam op_t OP_CLEAR    = 3'd6;
    localparam op_t OP_NOP      = 3'd7;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_INVALID   = 2'd3;

endpackage

// File: rtl/core/linear_probe_type_table_core.sv
// Keyed record table with open addressing and linear probing, one sequencer.
// Depends on lptt_pkg for operation and status codes.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   op, ids, traits, mask, crc, record index
//  m_        out        m_valid / m_ready   status, found, answer, record, entries used
//
// One operation is handled at a time. Each probe reads one bucket through the single
// bucket memory read port (S_PRD, then S_PCHK), after a hash state (a mask when
// BUCKET_COUNT is a power of two, else a bit-serial remainder) and before a decide
// state. Record reads pass S_RRD then S_RCHK; a crc search reads each stored record
// in turn. After reset, and for a clear operation, a pass over all BUCKET_COUNT
// buckets wipes the bucket used flags; s_ready stays low meanwhile. The finished
// result sits in an output register, so the next transfer is accepted while it
// waits for m_ready.

module linear_probe_type_table_core #(
    parameter int BUCKET_COUNT = 256,
    parameter int RECORD_CAP   = 192,
    parameter int MAX_HOPS     = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lptt_pkg::op_t         s_op,
    input  logic [31:0]           s_type_id,
    input  logic [31:0]           s_parent_id,
    input  logic [31:0]           s_ancestor_id,
    input  logic [31:0]           s_trait_bits,
    input  logic [31:0]           s_trait_mask,
    input  logic signed [31:0]    s_crc_value,
    input  logic [7:0]            s_record_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lptt_pkg::status_t     m_status,
    output logic                  m_found,
    output logic                  m_answer,
    output logic [31:0]           m_out_id,
    output logic [31:0]           m_out_parent,
    output logic [31:0]           m_out_traits,
    output logic signed [31:0]    m_out_crc,
    output logic [7:0]            m_out_slot,
    output logic [7:0]            m_entries_used
);
    import lptt_pkg::*;

    localparam int BIW = $clog2(BUCKET_COUNT);
    localparam int RAW = $clog2(RECORD_CAP);
    localparam int RIW = $clog2(RECORD_CAP + 1);
    localparam int HW  = $clog2(MAX_HOPS + 1);
    localparam int BW  = 1 + 32 + RAW;
    localparam bit POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
    localparam int LOAD_LIM = BUCKET_COUNT * 3;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HASH = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd2;
    localparam logic [3:0] S_PCHK = 4'd3;
    localparam logic [3:0] S_LKUP = 4'd4;
    localparam logic [3:0] S_INS  = 4'd5;
    localparam logic [3:0] S_RRD  = 4'd6;
    localparam logic [3:0] S_RCHK = 4'd7;
    localparam logic [3:0] S_WALK = 4'd8;
    localparam logic [3:0] S_SCAN = 4'd9;
    localparam logic [3:0] S_CLR  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // Bucket memory row: used flag, key, record slot. Record row: key, parent,
    // traits, crc.
    logic [BW-1:0]  bkt_mem [BUCKET_COUNT];
    logic [127:0]   rec_mem [RECORD_CAP];
    logic [BW-1:0]  bkt_rdata_reg;
    logic [127:0]   rec_rdata_reg;
    logic           bkt_we;
    logic [BIW-1:0] bkt_waddr;
    logic [BW-1:0]  bkt_wdata;
    logic           rec_we;

    logic [3:0]     state_reg, state_next;
    op_t            op_reg, op_next;
    logic [31:0]    id_reg, id_next, par_reg, par_next, anc_reg, anc_next;
    logic [31:0]    bits_reg, bits_next, mask_reg, mask_next, crc_reg, crc_next;
    logic [7:0]     ridx_reg, ridx_next;
    logic [31:0]    key_reg, key_next;
    logic [BIW-1:0] rem_reg, rem_next;
    logic [4:0]     hbit_reg, hbit_next;
    logic [BIW-1:0] idx_reg, idx_next;
    logic [BIW:0]   pcnt_reg, pcnt_next;
    logic           hit_reg, hit_next, nofree_reg, nofree_next;
    logic [RAW-1:0] slot_reg, slot_next, rec_addr_reg, rec_addr_next;
    logic [RIW-1:0] scan_reg, scan_next, total_reg, total_next;
    logic [HW-1:0]  hops_reg, hops_next;
    logic           walk_reg, walk_next, ans_reg, ans_next;
    logic [31:0]    cur_par_reg, cur_par_next;
    logic [BIW-1:0] clr_cnt_reg, clr_cnt_next;
    logic           clr_reply_reg, clr_reply_next;
    status_t        res_status_reg, res_status_next;
    logic           res_found_reg, res_found_next, res_answer_reg, res_answer_next;
    logic [31:0]    res_id_reg, res_id_next, res_parent_reg, res_parent_next;
    logic [31:0]    res_traits_reg, res_traits_next, res_crc_reg, res_crc_next;
    logic [7:0]     res_slot_reg, res_slot_next;
    logic           m_valid_reg, m_valid_next;
    status_t        m_status_reg;
    logic           m_found_reg, m_answer_reg;
    logic [31:0]    m_id_reg, m_parent_reg, m_traits_reg, m_crc_reg;
    logic [7:0]     m_slot_reg, m_used_reg;
    logic           m_load;

    logic           b_used;
    logic [31:0]    b_key;
    logic [RAW-1:0] b_slot;
    logic [31:0]    r_key, r_par, r_trt, r_crc;
    logic [BIW:0]   rem_try;
    logic           lk_ok;

    assign b_used = bkt_rdata_reg[BW-1];
    assign b_key  = bkt_rdata_reg[BW-2 -: 32];
    assign b_slot = bkt_rdata_reg[RAW-1:0];
    assign r_key  = rec_rdata_reg[127:96];
    assign r_par  = rec_rdata_reg[95:64];
    assign r_trt  = rec_rdata_reg[63:32];
    assign r_crc  = rec_rdata_reg[31:0];
    assign rem_try = {rem_reg, key_reg[hbit_reg]};
    assign lk_ok  = hit_reg && (RIW'(slot_reg) < total_reg);

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        bkt_rdata_reg <= bkt_mem[idx_reg];
        rec_rdata_reg <= rec_mem[rec_addr_reg];
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (rec_we) begin
            rec_mem[total_reg[RAW-1:0]] <= {id_reg, par_reg, bits_reg, crc_reg};
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        par_next        = par_reg;
        anc_next        = anc_reg;
        bits_next       = bits_reg;
        mask_next       = mask_reg;
        crc_next        = crc_reg;
        ridx_next       = ridx_reg;
        key_next        = key_reg;
        rem_next        = rem_reg;
        hbit_next       = hbit_reg;
        idx_next        = idx_reg;
        pcnt_next       = pcnt_reg;
        hit_next        = hit_reg;
        nofree_next     = nofree_reg;
        slot_next       = slot_reg;
        rec_addr_next   = rec_addr_reg;
        scan_next       = scan_reg;
        total_next      = total_reg;
        hops_next       = hops_reg;
        walk_next       = walk_reg;
        ans_next        = ans_reg;
        cur_par_next    = cur_par_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_answer_next = res_answer_reg;
        res_id_next     = res_id_reg;
        res_parent_next = res_parent_reg;
        res_traits_next = res_traits_reg;
        res_crc_next    = res_crc_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_load          = 1'b0;
        bkt_we          = 1'b0;
        bkt_waddr       = idx_reg;
        bkt_wdata       = {1'b1, id_reg, total_reg[RAW-1:0]};
        rec_we          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next = s_op;
                    id_next = s_type_id;
                    par_next = s_parent_id;
                    anc_next = s_ancestor_id;
                    bits_next = s_trait_bits;
                    mask_next = s_trait_mask;
                    crc_next = s_crc_value;
                    ridx_next = s_record_index;
                    res_status_next = ST_OK;
                    res_found_next = 1'b0;
                    res_answer_next = 1'b0;
                    res_id_next = '0;
                    res_parent_next = '0;
                    res_traits_next = '0;
                    res_crc_next = '0;
                    res_slot_next = '0;
                    key_next = s_type_id;
                    rem_next = '0;
                    hbit_next = 5'd31;
                    pcnt_next = '0;
                    walk_next = 1'b0;
                    hops_next = '0;
                    ans_next = (s_type_id == s_ancestor_id);
                    scan_next = '0;
                    unique case (s_op) inside
                        OP_INSERT, OP_FIND_ID, OP_HAS_TRT: begin
                            if (s_type_id == 32'd0) begin
                                res_status_next = (s_op == OP_INSERT) ? ST_INVALID
                                                                      : ST_NOT_FOUND;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_HASH;
                            end
                        end
                        OP_SUBTYPE: begin
                            // A zero key is never stored, so its lookup misses.
                            if (s_type_id == 32'd0) begin
                                res_status_next = ST_NOT_FOUND;
                                res_answer_next = (s_ancestor_id == 32'd0);
                                state_next = S_DONE;
                            end else begin
                                state_next = S_HASH;
                            end
                        end
                        OP_FIND_CRC: state_next = S_SCAN;
                        OP_READ_IDX: begin
                            if (32'(s_record_index) < 32'(total_reg)) begin
                                rec_addr_next = RAW'(s_record_index);
                                state_next = S_RRD;
                            end else begin
                                res_status_next = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            total_next = '0;
                            clr_cnt_next = '0;
                            clr_reply_next = 1'b1;
                            state_next = S_CLR;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_HASH: begin
                // Home bucket is key mod BUCKET_COUNT: a mask for a power of two,
                // otherwise one restoring remainder bit per cycle.
                if (POW2) begin
                    idx_next = key_reg[BIW-1:0];
                    state_next = S_PRD;
                end else begin
                    rem_next = (rem_try >= (BIW+1)'(BUCKET_COUNT))
                             ? BIW'(rem_try - (BIW+1)'(BUCKET_COUNT)) : BIW'(rem_try);
                    hbit_next = hbit_reg - 5'd1;
                    if (hbit_reg == 5'd0) begin
                        idx_next = rem_next;
                        state_next = S_PRD;
                    end
                end
            end
            S_PRD: state_next = S_PCHK;
            S_PCHK: begin
                if (!b_used) begin
                    hit_next = 1'b0;
                    nofree_next = 1'b0;
                    state_next = S_LKUP;
                end else if (b_key == key_reg) begin
                    hit_next = 1'b1;
                    slot_next = b_slot;
                    state_next = S_LKUP;
                end else if (pcnt_reg + (BIW+1)'(1) == (BIW+1)'(BUCKET_COUNT)) begin
                    hit_next = 1'b0;
                    nofree_next = 1'b1;
                    state_next = S_LKUP;
                end else begin
                    pcnt_next = pcnt_reg + (BIW+1)'(1);
                    idx_next = (idx_reg == BIW'(BUCKET_COUNT - 1)) ? '0
                                                                    : idx_reg + BIW'(1);
                    state_next = S_PRD;
                end
            end
            S_LKUP: begin
                rec_addr_next = slot_reg;
                if (op_reg == OP_INSERT) begin
                    if (hit_reg) begin
                        res_found_next = 1'b1;
                        state_next = lk_ok ? S_RRD : S_DONE;
                    end else if (nofree_reg || total_reg >= RIW'(RECORD_CAP)
                                 || ((32'(total_reg) + 32'd1) << 2) > 32'(LOAD_LIM)) begin
                        res_status_next = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_INS;
                    end
                end else if (lk_ok) begin
                    state_next = S_RRD;
                end else if (op_reg == OP_SUBTYPE && walk_reg) begin
                    // Missing ancestor record ends the walk.
                    res_answer_next = ans_reg;
                    state_next = S_DONE;
                end else begin
                    res_status_next = ST_NOT_FOUND;
                    res_answer_next = (op_reg == OP_SUBTYPE) ? ans_reg : 1'b0;
                    state_next = S_DONE;
                end
            end
            S_INS: begin
                bkt_we = 1'b1;
                rec_we = 1'b1;
                res_id_next = id_reg;
                res_parent_next = par_reg;
                res_traits_next = bits_reg;
                res_crc_next = crc_reg;
                res_slot_next = 8'(total_reg);
                total_next = total_reg + RIW'(1);
                state_next = S_DONE;
            end
            S_RRD: state_next = S_RCHK;
            S_RCHK: begin
                if (op_reg == OP_FIND_CRC && r_crc != crc_reg) begin
                    scan_next = scan_reg + RIW'(1);
                    state_next = S_SCAN;
                end else if (op_reg == OP_SUBTYPE && walk_reg) begin
                    cur_par_next = r_par;
                    state_next = S_WALK;
                end else begin
                    res_found_next = 1'b1;
                    res_id_next = r_key;
                    res_parent_next = r_par;
                    res_traits_next = r_trt;
                    res_crc_next = r_crc;
                    res_slot_next = 8'(rec_addr_reg);
                    res_answer_next = (op_reg == OP_HAS_TRT) && ((r_trt & mask_reg) != 0);
                    if (op_reg == OP_SUBTYPE) begin
                        walk_next = 1'b1;
                        cur_par_next = r_par;
                        state_next = S_WALK;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (ans_reg || cur_par_reg == 32'd0 || hops_reg == HW'(MAX_HOPS)) begin
                    res_answer_next = ans_reg;
                    state_next = S_DONE;
                end else if (cur_par_reg == anc_reg) begin
                    res_answer_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    key_next = cur_par_reg;
                    rem_next = '0;
                    hbit_next = 5'd31;
                    pcnt_next = '0;
                    hops_next = hops_reg + HW'(1);
                    state_next = S_HASH;
                end
            end
            S_SCAN: begin
                if (scan_reg < total_reg) begin
                    rec_addr_next = scan_reg[RAW-1:0];
                    state_next = S_RRD;
                end else begin
                    res_status_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
            end
            S_CLR: begin
                bkt_we = 1'b1;
                bkt_waddr = clr_cnt_reg;
                bkt_wdata = '0;
                clr_cnt_next = clr_cnt_reg + BIW'(1);
                if (clr_cnt_reg == BIW'(BUCKET_COUNT - 1)) begin
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        id_reg <= id_next;
        par_reg <= par_next;
        anc_reg <= anc_next;
        bits_reg <= bits_next;
        mask_reg <= mask_next;
        crc_reg <= crc_next;
        ridx_reg <= ridx_next;
        key_reg <= key_next;
        rem_reg <= rem_next;
        hbit_reg <= hbit_next;
        idx_reg <= idx_next;
        pcnt_reg <= pcnt_next;
        hit_reg <= hit_next;
        nofree_reg <= nofree_next;
        slot_reg <= slot_next;
        rec_addr_reg <= rec_addr_next;
        scan_reg <= scan_next;
        hops_reg <= hops_next;
        walk_reg <= walk_next;
        ans_reg <= ans_next;
        cur_par_reg <= cur_par_next;
        res_status_reg <= res_status_next;
        res_found_reg <= res_found_next;
        res_answer_reg <= res_answer_next;
        res_id_reg <= res_id_next;
        res_parent_reg <= res_parent_next;
        res_traits_reg <= res_traits_next;
        res_crc_reg <= res_crc_next;
        res_slot_reg <= res_slot_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_found_reg  <= res_found_reg;
            m_answer_reg <= res_answer_reg;
            m_id_reg     <= res_id_reg;
            m_parent_reg <= res_parent_reg;
            m_traits_reg <= res_traits_reg;
            m_crc_reg    <= res_crc_reg;
            m_slot_reg   <= res_slot_reg;
            m_used_reg   <= 8'(total_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_found        = m_found_reg;
    assign m_answer       = m_answer_reg;
    assign m_out_id       = m_id_reg;
    assign m_out_parent   = m_parent_reg;
    assign m_out_traits   = m_traits_reg;
    assign m_out_crc      = m_crc_reg;
    assign m_out_slot     = m_slot_reg;
    assign m_entries_used = m_used_reg;

    // The wipe pass never overlaps accepting a transfer.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_ready) else $error("accepted during clear pass");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= RIW'(RECORD_CAP)) else $error("record count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS) |=> (total_reg == $past(total_reg) + RIW'(1)))
        else $error("insert did not add one record");

    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> !m_found)
        else $error("full status with a found record");

endmodule
